>>> src/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds across reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/gtcd_pkg.sv
// types, codes and name tables of the gamepad text command decoder
`default_nettype none
package gtcd_pkg;

  // result kinds
  localparam logic [1:0] KIND_BUTTON = 2'd0;
  localparam logic [1:0] KIND_AXIS   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NO_SIGN   = 3'd1;
  localparam logic [2:0] ERR_BAD_BTN   = 3'd2;
  localparam logic [2:0] ERR_BAD_SIZE  = 3'd3;
  localparam logic [2:0] ERR_NO_COLON  = 3'd4;
  localparam logic [2:0] ERR_RANGE     = 3'd5;
  localparam logic [2:0] ERR_BAD_AXIS  = 3'd6;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd7;

  // characters
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  // header layout: sign/name bytes and colon position
  localparam int HDR_BYTES = 5;
  localparam int BUTTON_LEN = 5;
  localparam int AXIS_LEN_MIN = 6;
  localparam int AXIS_LEN_MAX = 10;

  // parsed number: up to five digits
  localparam int NUM_W = 17;
  localparam logic [NUM_W-1:0] NUM_LIMIT = NUM_W'(65535);
  localparam logic [15:0] AXIS_BIAS = 16'h8000;

  localparam int NUM_BUTTONS = 15;
  localparam int NUM_AXES = 6;

  localparam logic [31:0] BUTTON_NAMES [NUM_BUTTONS] = '{
    "BUTA", "BUTB", "BUTX", "BUTY", "BACK", "GUID", "STRT", "LSTK",
    "RSTK", "LSHD", "RSHD", "PADU", "PADD", "PADL", "PADR"
  };

  localparam logic [31:0] AXIS_NAMES [NUM_AXES] = '{
    "AXLX", "AXLY", "AXRX", "AXRY", "TRGL", "TRGR"
  };

  // one result word
  typedef struct packed {
    logic [1:0]         event_kind;
    logic [3:0]         control_index;
    logic               pressed;
    logic signed [15:0] axis_value;
    logic [2:0]         error_code;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic store;
    logic start;
    logic rd_en;
    logic load_result;
    logic load_overflow;
    logic is_button;
    logic len_ok;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_term;
  } stat_t;

  // table lookups: {hit, index}
  function automatic logic [4:0] find_button(input logic [31:0] name);
    logic [4:0] res;
    res = '0;
    for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
      if (BUTTON_NAMES[i] == name) res = {1'b1, 4'(i)};
    end
    return res;
  endfunction

  function automatic logic [4:0] find_axis(input logic [31:0] name);
    logic [4:0] res;
    res = '0;
    for (int i = NUM_AXES - 1; i >= 0; i--) begin
      if (AXIS_NAMES[i] == name) res = {1'b1, 4'(i)};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> src/gtcd_if.sv
// valid/ready channel interfaces for received bytes and decoded events
`default_nettype none
interface gtcd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface gtcd_event_if;
  logic               valid;
  logic               ready;
  logic [1:0]         event_kind;
  logic [3:0]         control_index;
  logic               pressed;
  logic signed [15:0] axis_value;
  logic [2:0]         error_code;

  modport source (output valid, output event_kind, output control_index, output pressed,
                  output axis_value, output error_code, input ready);
  modport sink (input valid, input event_kind, input control_index, input pressed,
                input axis_value, input error_code, output ready);
endinterface
`default_nettype wire

>>> src/gamepad_text_command_decoder_unit.sv
// Gamepad text command decoder, top level.
// rx carries one received byte per word; a newline or zero byte ends a line.
// ev carries one decoded word per finished line: a button press/release, an
// axis value (decimal minus 32768), or an error code. A non-terminator byte
// arriving when MAX_LINE bytes are already held gives an overflow error and
// clears the line. Ordinary bytes are stored and give no word.
// A terminator starts a walk over the stored line through the buffer's single
// registered read port, one byte per cycle, then a decode state; no byte is
// taken during the walk.
// The event word sits in an output register; while it waits, rx still takes
// bytes if the sink takes the word in the same cycle, otherwise rx stalls.
// Reset (rst, synchronous) empties the line and drops any pending word; the
// buffer contents need no clearing.
`default_nettype none
module gamepad_text_command_decoder_unit #(
  parameter int MAX_LINE = 11
) (
  input  wire logic     clk,
  input  wire logic     rst,
  gtcd_byte_if.sink     rx,
  gtcd_event_if.source  ev
);
  import gtcd_pkg::*;

  localparam int AW = $clog2(MAX_LINE);

  cmd_t          cmd;
  stat_t         stat;
  result_t       res;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  gtcd_ctrl #(.MAX_LINE(MAX_LINE)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rx.valid),
    .in_ready  (rx.ready),
    .out_valid (ev.valid),
    .out_ready (ev.ready),
    .stat      (stat),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr)
  );

  gtcd_dp #(.MAX_LINE(MAX_LINE)) u_dp (
    .clk     (clk),
    .rst     (rst),
    .rx_byte (rx.rx_byte),
    .cmd     (cmd),
    .wr_addr (wr_addr),
    .rd_addr (rd_addr),
    .stat    (stat),
    .res     (res)
  );

  // event word fields
  assign ev.event_kind    = res.event_kind;
  assign ev.control_index = res.control_index;
  assign ev.pressed       = res.pressed;
  assign ev.axis_value    = res.axis_value;
  assign ev.error_code    = res.error_code;

endmodule
`default_nettype wire

>>> src/gtcd_dp.sv
// datapath: line buffer, header and number capture, decode and result register
`default_nettype none
module gtcd_dp #(
  parameter int MAX_LINE = 11
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [7:0]                        rx_byte,
  input  wire gtcd_pkg::cmd_t                    cmd,
  input  wire logic [$clog2(MAX_LINE)-1:0]       wr_addr,
  input  wire logic [$clog2(MAX_LINE)-1:0]       rd_addr,
  output gtcd_pkg::stat_t                        stat,
  output gtcd_pkg::result_t                      res
);
  import gtcd_pkg::*;

  localparam int AW = $clog2(MAX_LINE);

  logic [7:0]       line_mem [MAX_LINE];
  logic [7:0]       rd_data;
  logic             rd_vld;
  logic [AW-1:0]    rd_pos;
  logic [7:0]       hdr [HDR_BYTES];
  logic [NUM_W-1:0] num;
  logic             num_stop;
  logic             is_digit;
  logic [4:0]       btn_hit;
  logic [4:0]       axis_hit;
  result_t          res_next;

  // terminator detect
  assign stat.is_term = (rx_byte == CH_NEWLINE) || (rx_byte == CH_NUL);

  // line buffer, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.store) line_mem[wr_addr] <= rx_byte;
    if (cmd.rd_en) rd_data <= line_mem[rd_addr];
    rd_pos <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) rd_vld <= 1'b0;
    else     rd_vld <= cmd.rd_en;
  end

  assign is_digit = (rd_data >= CH_ZERO) && (rd_data <= CH_NINE);

  // header bytes and decimal accumulation from the walked line
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      num      <= '0;
      num_stop <= 1'b0;
    end else if (rd_vld) begin
      if (rd_pos < AW'(HDR_BYTES)) begin
        hdr[rd_pos[2:0]] <= rd_data;
      end else if (!num_stop) begin
        if (is_digit) num <= NUM_W'(num * NUM_W'(10)) + NUM_W'(rd_data - CH_ZERO);
        else          num_stop <= 1'b1;
      end
    end
  end

  assign btn_hit  = find_button({hdr[1], hdr[2], hdr[3], hdr[4]});
  assign axis_hit = find_axis({hdr[0], hdr[1], hdr[2], hdr[3]});

  // line decode, first failing check wins
  always_comb begin
    res_next = '0;
    if (cmd.load_overflow) begin
      res_next.event_kind = KIND_ERROR;
      res_next.error_code = ERR_OVERFLOW;
    end else if (cmd.is_button) begin
      if (hdr[0] != CH_PLUS && hdr[0] != CH_MINUS) begin
        res_next.event_kind = KIND_ERROR;
        res_next.error_code = ERR_NO_SIGN;
      end else if (!btn_hit[4]) begin
        res_next.event_kind = KIND_ERROR;
        res_next.error_code = ERR_BAD_BTN;
      end else begin
        res_next.event_kind    = KIND_BUTTON;
        res_next.control_index = btn_hit[3:0];
        res_next.pressed       = (hdr[0] == CH_PLUS);
      end
    end else if (!cmd.len_ok) begin
      res_next.event_kind = KIND_ERROR;
      res_next.error_code = ERR_BAD_SIZE;
    end else if (hdr[4] != CH_COLON) begin
      res_next.event_kind = KIND_ERROR;
      res_next.error_code = ERR_NO_COLON;
    end else if (num > NUM_LIMIT) begin
      res_next.event_kind = KIND_ERROR;
      res_next.error_code = ERR_RANGE;
    end else if (!axis_hit[4]) begin
      res_next.event_kind = KIND_ERROR;
      res_next.error_code = ERR_BAD_AXIS;
    end else begin
      res_next.event_kind    = KIND_AXIS;
      res_next.control_index = axis_hit[3:0];
      res_next.axis_value    = signed'(num[15:0] ^ AXIS_BIAS);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_result || cmd.load_overflow) res <= res_next;
  end

endmodule
`default_nettype wire

>>> src/gtcd_ctrl.sv
// controller: byte count, line walk sequencing and output valid
`default_nettype none
module gtcd_ctrl #(
  parameter int MAX_LINE = 11
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  input  wire gtcd_pkg::stat_t             stat,
  output gtcd_pkg::cmd_t                   cmd,
  output logic [$clog2(MAX_LINE)-1:0]      wr_addr,
  output logic [$clog2(MAX_LINE)-1:0]      rd_addr
);
  import gtcd_pkg::*;

  localparam int CW = $clog2(MAX_LINE + 1);
  localparam int AW = $clog2(MAX_LINE);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_WALK   = 3'b010,
    ST_DECODE = 3'b100
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] byte_count, byte_count_next;
  logic [CW-1:0] line_len, line_len_next;
  logic [CW-1:0] walk_idx, walk_idx_next;
  logic          out_valid_next;
  logic          accept;

  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign wr_addr  = byte_count[AW-1:0];
  assign rd_addr  = walk_idx[AW-1:0];

  // sequencing
  always_comb begin
    state_next      = state;
    byte_count_next = byte_count;
    line_len_next   = line_len;
    walk_idx_next   = walk_idx;
    cmd             = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (stat.is_term) begin
            cmd.start       = 1'b1;
            line_len_next   = byte_count;
            byte_count_next = '0;
            walk_idx_next   = '0;
            state_next      = ST_WALK;
          end else if (byte_count >= CW'(MAX_LINE)) begin
            cmd.load_overflow = 1'b1;
            byte_count_next   = '0;
          end else begin
            cmd.store       = 1'b1;
            byte_count_next = byte_count + CW'(1);
          end
        end
      end
      ST_WALK: begin
        if (walk_idx < line_len) begin
          cmd.rd_en     = 1'b1;
          walk_idx_next = walk_idx + CW'(1);
        end else begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.load_result = 1'b1;
        cmd.is_button   = (line_len == CW'(BUTTON_LEN));
        cmd.len_ok      = (line_len >= CW'(AXIS_LEN_MIN)) && (line_len <= CW'(AXIS_LEN_MAX));
        state_next      = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // output word valid
  always_comb begin
    if (cmd.load_result || cmd.load_overflow) out_valid_next = 1'b1;
    else if (out_ready)                       out_valid_next = 1'b0;
    else                                      out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      byte_count <= '0;
      line_len   <= '0;
      walk_idx   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      byte_count <= byte_count_next;
      line_len   <= line_len_next;
      walk_idx   <= walk_idx_next;
      out_valid  <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

>>> src/gtcd_checker.sv
// port-level checks of the decoder and their binding to the top level
`default_nettype none
`include "assert_macros.svh"
module gtcd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        ev_valid,
  input wire logic        ev_ready,
  input wire logic [1:0]  ev_kind,
  input wire logic [3:0]  ev_index,
  input wire logic        ev_pressed,
  input wire logic [15:0] ev_value,
  input wire logic [2:0]  ev_error
);
  import gtcd_pkg::*;

  // a pending word is not withdrawn
  `ASSERT_CLK(a_hold, clk, rst, ev_valid && !ev_ready |=> ev_valid, "event word withdrawn")

  // reset drops any pending word
  `ASSERT_ALWAYS(a_reset, clk, rst |=> !ev_valid, "event word valid after reset")

  // error words carry a code and nothing else
  `ASSERT_CLK(a_error, clk, rst, ev_valid && ev_kind == KIND_ERROR |-> ev_error != ERR_NONE && ev_index == 4'd0 && !ev_pressed && ev_value == 16'd0, "malformed error word")

  // event words carry no error code and fit their kind
  `ASSERT_CLK(a_event, clk, rst, ev_valid && ev_kind != KIND_ERROR |-> ev_error == ERR_NONE && (ev_kind == KIND_BUTTON || (ev_kind == KIND_AXIS && ev_index < 4'd6 && !ev_pressed)), "malformed event word")

endmodule

bind gamepad_text_command_decoder_unit gtcd_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .ev_valid   (ev.valid),
  .ev_ready   (ev.ready),
  .ev_kind    (ev.event_kind),
  .ev_index   (ev.control_index),
  .ev_pressed (ev.pressed),
  .ev_value   (ev.axis_value),
  .ev_error   (ev.error_code)
);
`default_nettype wire

>>> verif/gamepad_text_command_decoder_unit_tb.sv
// self-checking testbench for the gamepad text command decoder: directed, stall and random lines
module gamepad_text_command_decoder_unit_tb;
  import gtcd_pkg::*;

  localparam int LINE_CAP     = 11;
  localparam int STALL_CYCLES = 300;
  localparam int QUIET_LIMIT  = 3000;
  localparam int RANDOM_BYTES = 1130;
  localparam int CALM_BYTES   = 300;
  localparam int DRAIN_CYCLES = 2 * (LINE_CAP + 3) + 4;
  localparam int AXIS_NUM_MAX = 65535;
  localparam int AXIS_ZERO    = 32768;

  localparam logic [31:0] BTN_TAGS [15] = '{
    "BUTA", "BUTB", "BUTX", "BUTY", "BACK", "GUID", "STRT", "LSTK",
    "RSTK", "LSHD", "RSHD", "PADU", "PADD", "PADL", "PADR"
  };
  localparam logic [31:0] AXIS_TAGS [6] = '{
    "AXLX", "AXLY", "AXRX", "AXRY", "TRGL", "TRGR"
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  gtcd_byte_if  rx_if ();
  gtcd_event_if ev_if ();

  gamepad_text_command_decoder_unit #(.MAX_LINE(LINE_CAP)) u_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .ev  (ev_if)
  );

  // predictor state: collected line and the words still owed by the block
  logic [7:0] line_bytes [LINE_CAP];
  int         line_len = 0;
  result_t    pending_events [$];

  int mismatch_count = 0;
  int bytes_sent     = 0;
  int quiet_cycles   = 0;
  int stall_left     = 0;
  bit stall_request  = 1'b0;
  bit idle_on        = 1'b1;

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // decode a finished line of len stored bytes
  function automatic result_t decode_command(input int len);
    result_t     r;
    logic [31:0] tag;
    int          num;
    int          i;
    bit          digits_done;
    bit          found;
    r = '0;
    found = 1'b0;
    if (len == BUTTON_LEN) begin
      if (line_bytes[0] != CH_PLUS && line_bytes[0] != CH_MINUS) begin
        r.event_kind = KIND_ERROR;
        r.error_code = ERR_NO_SIGN;
        return r;
      end
      tag = {line_bytes[1], line_bytes[2], line_bytes[3], line_bytes[4]};
      for (i = 0; i < 15; i++) begin
        if (!found && BTN_TAGS[i] == tag) begin
          found = 1'b1;
          r.event_kind = KIND_BUTTON;
          r.control_index = 4'(i);
          r.pressed = (line_bytes[0] == CH_PLUS);
        end
      end
      if (!found) begin
        r.event_kind = KIND_ERROR;
        r.error_code = ERR_BAD_BTN;
      end
      return r;
    end
    if (len < AXIS_LEN_MIN || len > AXIS_LEN_MAX) begin
      r.event_kind = KIND_ERROR;
      r.error_code = ERR_BAD_SIZE;
      return r;
    end
    if (line_bytes[4] != CH_COLON) begin
      r.event_kind = KIND_ERROR;
      r.error_code = ERR_NO_COLON;
      return r;
    end
    // digits from the byte after the colon, stopping at the first non-digit
    num = 0;
    digits_done = 1'b0;
    for (i = HDR_BYTES; i < len; i++) begin
      if (line_bytes[i] < CH_ZERO || line_bytes[i] > CH_NINE) digits_done = 1'b1;
      if (!digits_done) num = num * 10 + int'(line_bytes[i] - CH_ZERO);
    end
    if (num > AXIS_NUM_MAX) begin
      r.event_kind = KIND_ERROR;
      r.error_code = ERR_RANGE;
      return r;
    end
    tag = {line_bytes[0], line_bytes[1], line_bytes[2], line_bytes[3]};
    for (i = 0; i < 6; i++) begin
      if (!found && AXIS_TAGS[i] == tag) begin
        found = 1'b1;
        r.event_kind = KIND_AXIS;
        r.control_index = 4'(i);
        r.axis_value = 16'(num - AXIS_ZERO);
      end
    end
    if (!found) begin
      r.event_kind = KIND_ERROR;
      r.error_code = ERR_BAD_AXIS;
    end
    return r;
  endfunction

  // advance the predictor by one accepted byte; returns 1 when a word is owed
  function automatic bit take_rx_byte(input logic [7:0] b, output result_t r);
    int len;
    r = '0;
    if (b == CH_NEWLINE || b == CH_NUL) begin
      len = line_len;
      line_len = 0;
      r = decode_command(len);
      return 1'b1;
    end
    if (line_len >= LINE_CAP) begin
      line_len = 0;
      r.event_kind = KIND_ERROR;
      r.error_code = ERR_OVERFLOW;
      return 1'b1;
    end
    line_bytes[line_len] = b;
    line_len++;
    return 1'b0;
  endfunction

  // any byte but a terminator, half of them from the command alphabet
  function automatic logic [7:0] noise_byte();
    string      alphabet = "+-:0123456789ABCDGKLPRSTUXY ";
    logic [7:0] b;
    if ($urandom_range(1)) return alphabet[$urandom_range(alphabet.len() - 1)];
    do b = 8'($urandom_range(255)); while (b == CH_NEWLINE || b == CH_NUL);
    return b;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    if (mismatch_count < 40)
      $display("%0t: %s mismatch: got %0d, expected %0d", $time, field, got, want);
    mismatch_count++;
  endtask

  // offer one byte until it is taken, then predict
  task automatic send_byte(input logic [7:0] b);
    result_t ev_word;
    while (idle_on && $urandom_range(99) < 9) begin
      rx_if.valid <= 1'b0;
      @(posedge clk);
    end
    rx_if.valid <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
    if (take_rx_byte(b, ev_word)) pending_events.push_back(ev_word);
    bytes_sent++;
  endtask

  task automatic send_line(input string text, input logic [7:0] term);
    int k;
    for (k = 0; k < text.len(); k++) send_byte(text[k]);
    send_byte(term);
  endtask

  // receiver: random idling, or a long hold-off on request
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      ev_if.ready <= 1'b0;
    end else if (stall_request) begin
      stall_request = 1'b0;
      stall_left = STALL_CYCLES;
      ev_if.ready <= 1'b0;
    end else begin
      ev_if.ready <= !idle_on || ($urandom_range(99) >= 9);
    end
  end

  // compare each taken word with the oldest prediction
  always @(posedge clk) begin : check_events
    result_t want;
    if (!rst && ev_if.valid && ev_if.ready) begin
      if (pending_events.size() == 0) begin
        report_mismatch("word with nothing pending, event_kind", ev_if.event_kind, -1);
      end else begin
        want = pending_events.pop_front();
        if (ev_if.event_kind !== want.event_kind)
          report_mismatch("event_kind", ev_if.event_kind, want.event_kind);
        if (ev_if.control_index !== want.control_index)
          report_mismatch("control_index", ev_if.control_index, want.control_index);
        if (ev_if.pressed !== want.pressed)
          report_mismatch("pressed", ev_if.pressed, want.pressed);
        if (ev_if.axis_value !== want.axis_value)
          report_mismatch("axis_value", ev_if.axis_value, want.axis_value);
        if (ev_if.error_code !== want.error_code)
          report_mismatch("error_code", ev_if.error_code, want.error_code);
      end
    end
  end

  // cycles with no word moving on either side
  always @(posedge clk) begin
    if ((rx_if.valid && rx_if.ready) || (ev_if.valid && ev_if.ready)) quiet_cycles = 0;
    else quiet_cycles++;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  // edges of every check the decoder applies
  task automatic test_directed_commands;
    send_line("+BUTA", CH_NEWLINE);
    send_line("-PADR", CH_NUL);
    send_line("+GUID", CH_NEWLINE);
    send_line("*BUTA", CH_NEWLINE);
    send_line("+BUTZ", CH_NEWLINE);
    send_line("", CH_NEWLINE);
    send_line("AXL", CH_NUL);
    send_line("AXLY:", CH_NEWLINE);
    send_line("AXLX:0", CH_NEWLINE);
    send_line("TRGR:65535", CH_NEWLINE);
    send_line("AXRX:32768", CH_NUL);
    send_line("AXLY:65536", CH_NEWLINE);
    send_line("ABCD:99999", CH_NEWLINE);
    send_line("AXRY;12", CH_NEWLINE);
    send_line("TRGX:12", CH_NEWLINE);
    send_line("TRGL: 99", CH_NEWLINE);
    send_line("AXLX:-5", CH_NEWLINE);
    send_line("AXRY:7x3", CH_NUL);
    send_line("AXLX:123456", CH_NEWLINE);
    // twelfth byte overflows, then the terminator closes an empty line
    send_line("AXLX:1234567", CH_NEWLINE);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(CH_NEWLINE);
  endtask

  // hold the event side off while lines keep coming, so rx backs up
  task automatic test_output_stall;
    int k;
    stall_request = 1'b1;
    for (k = 0; k < 30; k++) begin
      if (k % 2) send_line("-LSHD", CH_NEWLINE);
      else send_line("AXRX:12345", CH_NUL);
    end
  endtask

  // mostly well-formed commands with random content, plus noise and overruns
  task automatic test_random_traffic;
    logic [7:0]  cmd_bytes [$];
    logic [31:0] tag;
    string       num_text;
    int          start_count;
    int          pick;
    int          n;
    int          k;
    start_count = bytes_sent;
    while (bytes_sent < start_count + RANDOM_BYTES) begin
      idle_on = (bytes_sent - start_count >= CALM_BYTES);
      cmd_bytes.delete();
      num_text = "";
      pick = $urandom_range(99);
      if (pick < 35) begin
        // button command
        cmd_bytes.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
        tag = BTN_TAGS[$urandom_range(14)];
        for (k = 3; k >= 0; k--) cmd_bytes.push_back(tag[k*8 +: 8]);
      end else if (pick < 70) begin
        // axis command
        tag = AXIS_TAGS[$urandom_range(5)];
        for (k = 3; k >= 0; k--) cmd_bytes.push_back(tag[k*8 +: 8]);
        cmd_bytes.push_back(CH_COLON);
        case ($urandom_range(9))
          0: num_text = "65535";
          1: num_text = "65536";
          2: num_text = "99999";
          3: num_text = "32768";
          4: num_text = $sformatf("%s%0d", $urandom_range(1) ? "-" : " ", $urandom_range(999));
          default: begin
            n = $urandom_range(5);
            for (k = 0; k < n; k++) cmd_bytes.push_back(8'(CH_ZERO + $urandom_range(9)));
          end
        endcase
        for (k = 0; k < num_text.len(); k++) cmd_bytes.push_back(num_text[k]);
      end else if (pick < 92) begin
        // noise line of any length the store can hold
        n = $urandom_range(LINE_CAP);
        for (k = 0; k < n; k++) cmd_bytes.push_back(noise_byte());
      end else begin
        // overrun past the end of the store
        n = $urandom_range(LINE_CAP + 5, LINE_CAP + 1);
        for (k = 0; k < n; k++) cmd_bytes.push_back(noise_byte());
      end
      // occasionally break one byte of a well-formed command
      if (pick < 70 && $urandom_range(9) == 0)
        cmd_bytes[$urandom_range(cmd_bytes.size() - 1)] = noise_byte();
      // overruns sometimes run straight into the next line
      if (pick < 92 || $urandom_range(1))
        cmd_bytes.push_back($urandom_range(1) ? CH_NEWLINE : CH_NUL);
      for (k = 0; k < cmd_bytes.size(); k++) send_byte(cmd_bytes[k]);
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rx_if.valid = 1'b0;
    rx_if.rx_byte = '0;
    ev_if.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_commands();
    test_output_stall();
    test_random_traffic();
    rx_if.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_events.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
